// ===== rtl/ibpr_pkg.sv =====
// Shared types, constants and register codes of the isolated black pixel removal unit.
package ibpr_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W = $clog2(MAX_WIDTH);

    localparam int FRAME_WIDTH_W = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int THRESH_W = 4;
    localparam int PIXEL_W = 24;

    // Width comparisons need room for MAX_WIDTH itself and for the register value.
    localparam int CMP_W = (COL_W + 1 > FRAME_WIDTH_W) ? COL_W + 1 : FRAME_WIDTH_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_THRESHOLD = 2'd2;

    localparam logic [FRAME_WIDTH_W-1:0] FRAME_WIDTH_RESET = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd480;
    localparam logic [THRESH_W-1:0] WHITE_THRESHOLD_RESET = 4'd5;

    localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 24'hFF_FFFF;
    localparam logic [PIXEL_W-1:0] PIXEL_BLACK = 24'h00_0000;

    // Line buffer entry: whiteness of row r-2 above the pixel of row r-1.
    localparam int LINE_W = PIXEL_W + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef logic [PIXEL_W-1:0] pixel_t;

    // Everything about one accepted item that does not depend on the line buffer.
    typedef struct packed {
        logic [COL_W-1:0] col;
        pixel_t           px;
        logic             primed;
        logic             interior;
        logic             last;
    } item_t;

    typedef struct packed {
        pixel_t px;
        logic   last;
    } result_t;

endpackage

// ===== rtl/ibpr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ibpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ibpr_ctrl.sv =====
// Configuration registers and the raster position counters of input and output.
module ibpr_ctrl import ibpr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  accept,
    input  pixel_t                in_px,
    input  logic                  in_drain,
    output item_t                 item_o,
    output logic [THRESH_W-1:0]   threshold_o
);

    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [THRESH_W-1:0]       threshold_reg;

    logic [COL_W-1:0]          in_col_reg, in_col_next;
    logic [1:0]                in_row_reg, in_row_next;
    logic [COL_W-1:0]          out_col_reg, out_col_next;
    logic [FRAME_HEIGHT_W-1:0] out_row_reg, out_row_next;

    logic [CMP_W-1:0]          w_eff;
    logic [FRAME_HEIGHT_W:0]   h_eff;
    logic [COL_W-1:0]          col, oc;
    logic [CMP_W-1:0]          col_inc, oc_inc;
    logic [FRAME_HEIGHT_W:0]   orow_inc;
    logic                      col_wrap, oc_wrap, primed, last, interior;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            threshold_reg <= WHITE_THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: frame_width_reg <= cfg_wdata[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FRAME_HEIGHT_W-1:0];
                REG_WHITE_THRESHOLD: threshold_reg <= cfg_wdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(frame_width_reg) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(frame_width_reg);
        end
        h_eff = (frame_height_reg == '0) ? (FRAME_HEIGHT_W+1)'(1)
                                         : {1'b0, frame_height_reg};

        col = (CMP_W'(in_col_reg) >= w_eff) ? '0 : in_col_reg;
        col_inc = CMP_W'(col) + CMP_W'(1);
        col_wrap = col_inc >= w_eff;
        primed = (in_row_reg >= 2'd2) || (in_row_reg == 2'd1 && col != '0);

        oc = (CMP_W'(out_col_reg) >= w_eff) ? '0 : out_col_reg;
        oc_inc = CMP_W'(oc) + CMP_W'(1);
        oc_wrap = oc_inc >= w_eff;
        orow_inc = {1'b0, out_row_reg} + (FRAME_HEIGHT_W+1)'(1);
        last = (orow_inc >= h_eff) && oc_wrap;
        interior = (out_row_reg != '0) && (orow_inc < h_eff) && (oc != '0) && !oc_wrap;

        in_col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
        in_row_next = (col_wrap && in_row_reg != 2'd2) ? in_row_reg + 2'd1 : in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (primed) begin
            if (last) begin
                in_col_next = '0;
                in_row_next = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else if (oc_wrap) begin
                out_col_next = '0;
                out_row_next = orow_inc[FRAME_HEIGHT_W-1:0];
            end else begin
                out_col_next = oc_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (accept) begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // A drain item enters the window as a black pixel.
    assign item_o.col = col;
    assign item_o.px = in_drain ? PIXEL_BLACK : in_px;
    assign item_o.primed = primed;
    assign item_o.interior = interior;
    assign item_o.last = last;
    assign threshold_o = threshold_reg;

`ifndef SYNTH
    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && primed && last) |=> (in_col_reg == '0 && in_row_reg == '0 &&
                                        out_col_reg == '0 && out_row_reg == '0))
        else $error("counters not cleared after the last item of a frame");
`endif

endmodule

// ===== rtl/ibpr_out_fifo.sv =====
// Small output queue that decouples the window stage from the result channel.
module ibpr_out_fifo import ibpr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  result_t             push_data,
    output logic [FIFO_PTR_W:0] count_o,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [PIXEL_W-1:0]  m_tdata,
    output logic                m_tlast
);

    result_t                entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W:0]    count_reg, count_next;
    logic                   pop;

    assign pop = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (FIFO_PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (FIFO_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign m_tvalid = count_reg != '0;
    assign m_tdata = entries_reg[rd_ptr_reg].px;
    assign m_tlast = entries_reg[rd_ptr_reg].last;
    assign count_o = count_reg;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < (FIFO_PTR_W+1)'(FIFO_DEPTH)))
        else $error("result queue written while full");
`endif

endmodule

// ===== rtl/ibpr_window.sv =====
// Line buffer access, 3x3 whiteness window and the whitening decision.
module ibpr_window import ibpr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  item_t               item_i,
    input  logic [THRESH_W-1:0] threshold_i,
    output logic                busy_o,
    output logic                res_valid_o,
    output result_t             res_o
);

    item_t              s1_reg;
    logic               s1_valid_reg;
    logic               fwd_reg;
    logic [LINE_W-1:0]  last_wr_reg;
    logic [8:0]         wwb_reg;
    pixel_t             center_reg;

    logic [LINE_W-1:0]  rd_data, line, wr_data;
    pixel_t             mid_px;
    logic               mid_white, px_white;
    logic [8:0]         wwb_next;
    logic [3:0]         white_count;
    pixel_t             res_px;

    // Row r-2 whiteness and row r-1 pixel share one entry per column.
    ibpr_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_reg.col),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (item_i.col),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= item_i;
        end
        if (s1_valid_reg) begin
            last_wr_reg <= wr_data;
        end
    end

    // When the read was issued in the cycle that the previous item wrote the same
    // column (single-column frames), the RAM returned stale data: take the write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg <= 1'b0;
            wwb_reg <= '0;
            center_reg <= '0;
        end else begin
            s1_valid_reg <= accept;
            fwd_reg <= accept && s1_valid_reg && (s1_reg.col == item_i.col);
            if (s1_valid_reg) begin
                wwb_reg <= wwb_next;
                center_reg <= mid_px;
            end
        end
    end

    always_comb begin
        line = fwd_reg ? last_wr_reg : rd_data;
        mid_px = line[PIXEL_W-1:0];
        mid_white = mid_px == PIXEL_WHITE;
        px_white = s1_reg.px == PIXEL_WHITE;
        wr_data = {mid_white, s1_reg.px};
        wwb_next = {wwb_reg[5:0], line[PIXEL_W], mid_white, px_white};

        white_count = '0;
        for (int i = 0; i < 9; i++) begin
            white_count = white_count + {3'b000, wwb_next[i]};
        end

        res_px = center_reg;
        if (center_reg == PIXEL_BLACK && s1_reg.interior && white_count >= threshold_i) begin
            res_px = PIXEL_WHITE;
        end
    end

    assign busy_o = s1_valid_reg;
    assign res_valid_o = s1_valid_reg && s1_reg.primed;
    assign res_o.px = res_px;
    assign res_o.last = s1_reg.last;

`ifndef SYNTH
    a_fwd_with_item: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> s1_valid_reg)
        else $error("line buffer forwarding without an item in the window stage");
`endif

endmodule

// ===== rtl/isolated_black_pixel_removal_3x3_unit.sv =====
// Isolated black pixel removal over a 3x3 window on a raster RGB item stream.
// The unit takes one item per clock while the queue has room and gives at most one
// result per clock. A result is queued from the window stage register once the item
// that completes its window is accepted; results of a frame begin once width+1 items
// of it are in, so width+1 drain items must follow each frame. The sustained rate of
// one item per cycle is set by the single line buffer RAM (1024 x 25 bits), read when
// an item is accepted and written in the cycle after, with forwarding between adjacent
// items on the same column. A four-entry result queue lets input continue while a
// result waits. The line buffer needs no clearing pass after reset.
module isolated_black_pixel_removal_3x3_unit import ibpr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // red_in, green_in, blue_in
    input  logic                  s_tuser,   // drain
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // red_out, green_out, blue_out
    output logic                  m_tlast,   // frame_last
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic                accept;
    item_t               item;
    logic [THRESH_W-1:0] threshold;
    logic                busy;
    logic                res_valid;
    result_t             res;
    logic [FIFO_PTR_W:0] fifo_count;
    logic [FIFO_PTR_W:0] committed;

    // A primed item in the window stage lands in the queue, so count every such item as taken.
    assign committed = fifo_count + {{FIFO_PTR_W{1'b0}}, busy};
    assign s_tready = committed < (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign accept = s_tvalid && s_tready;

    ibpr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .in_px       (s_tdata),
        .in_drain    (s_tuser),
        .item_o      (item),
        .threshold_o (threshold)
    );

    ibpr_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .item_i      (item),
        .threshold_i (threshold),
        .busy_o      (busy),
        .res_valid_o (res_valid),
        .res_o       (res)
    );

    ibpr_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .count_o   (fifo_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
